// ===== src/vector_distance_metric_unit_defines.svh =====
// Assertion macros shared by the vector distance unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VECTOR_DISTANCE_METRIC_UNIT_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define VDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define VDM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/vdm_pkg.sv =====
package vdm_pkg;

  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned NORM_W      = 32;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned DIST_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_NORM  = 1'b1;

  typedef enum logic [1:0] {
    METRIC_EUCLID  = 2'd0,
    METRIC_COSINE  = 2'd1,
    METRIC_DOT     = 2'd2,
    METRIC_INVALID = 2'd3
  } metric_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] vec_element;
    logic signed [ELEM_W-1:0] query_element;
    logic [NORM_W-1:0]        stored_norm;
    logic                     last_element;
  } in_word_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     is_infinite;
  } out_word_t;

  // One finished dot product waiting for the back end
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [NORM_W-1:0]       stored_norm;
  } job_t;

endpackage

// ===== src/vdm_front.sv =====
module vdm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  vdm_pkg::in_word_t in_data_i,
  output logic              job_push_o,
  output vdm_pkg::job_t     job_o,
  input  logic              job_full_i
);
  import vdm_pkg::*;

  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [2*ELEM_W-1:0]  prod;
  logic signed [ACC_W:0]       sum;
  logic signed [ACC_W-1:0]     sat;
  logic                        accept;

  // Stall the element stream whenever the job queue has no room
  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  // Multiply one pair and add it to the running dot product
  assign prod = in_data_i.vec_element * in_data_i.query_element;
  assign sum  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod);

  // Clamp to the accumulator range
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat = sum[ACC_W-1:0];
    end
  end

  // Hand the finished dot product to the back end on the last pair
  assign job_push_o        = accept && in_data_i.last_element;
  assign job_o.dot         = sat;
  assign job_o.stored_norm = in_data_i.stored_norm;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = in_data_i.last_element ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== src/vdm_queue.sv =====
`include "vector_distance_metric_unit_defines.svh"

module vdm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vdm_pkg::job_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output vdm_pkg::job_t entry_o,
  output logic          empty_o
);
  import vdm_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `VDM_ASSERT(a_count_bound, count_q <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count out of range")
  `VDM_NEVER(a_push_full, push_i && full_o, "push into full job queue")
  `VDM_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty job queue")

endmodule

// ===== src/vdm_back.sv =====
`include "vector_distance_metric_unit_defines.svh"

module vdm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vdm_pkg::metric_e            metric_mode_i,
  input  logic [vdm_pkg::NORM_W-1:0]  probe_norm_i,
  input  logic                        job_empty_i,
  input  vdm_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output vdm_pkg::out_word_t          out_data_o
);
  import vdm_pkg::*;

  localparam int unsigned WIDE_W   = 128;
  localparam int unsigned OUT_SH   = 38;
  localparam int unsigned DOT_FRAC = 30;

  localparam logic [WIDE_W-1:0] RND_HALF = WIDE_W'(1) << (OUT_SH - 1);
  localparam logic signed [ACC_W+1:0] COS_BIAS = (ACC_W+2)'((64'd1 << DOT_FRAC) + 64'd32);
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PN, S_T0, S_T1, S_T2, S_T3, S_QQ, S_VV, S_SGN, S_COMB, S_RND, S_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic signed [ACC_W-1:0] dot_q, dot_d;
  logic [ACC_W-1:0]        mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [NORM_W-1:0]       vn_q, vn_d;
  logic [2*NORM_W-1:0]     pn_q, pn_d;
  logic [WIDE_W-1:0]       t_q, t_d;
  logic [WIDE_W-1:0]       e_q, e_d;
  logic                    ez_q, ez_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_q, out_d;

  logic [NORM_W-1:0]       mul_a, mul_b;
  logic [2*NORM_W-1:0]     prod;
  logic [WIDE_W-1:0]       prod_w;
  logic [WIDE_W-1:0]       rsum;
  logic signed [ACC_W+1:0] cos_w;
  logic [DIST_W-1:0]       sat_dist;
  logic                    sat_ok;
  logic                    deq, load;
  out_word_t               result;

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;
  assign job_pop_o  = deq;
  assign deq        = (state_q == S_IDLE) && !job_empty_i;
  assign load       = (state_q == S_OUT) && (!out_valid_q || pop_i);

  // Pick operands for the shared 32x32 multiplier
  always_comb begin
    mul_a = probe_norm_i;
    mul_b = vn_q;
    case (state_q)
      S_T0: begin
        mul_a = pn_q[NORM_W-1:0];
        mul_b = mag_q[NORM_W-1:0];
      end
      S_T1: begin
        mul_a = pn_q[2*NORM_W-1:NORM_W];
        mul_b = mag_q[NORM_W-1:0];
      end
      S_T2: begin
        mul_a = pn_q[NORM_W-1:0];
        mul_b = NORM_W'(mag_q[ACC_W-1:NORM_W]);
      end
      S_T3: begin
        mul_a = pn_q[2*NORM_W-1:NORM_W];
        mul_b = NORM_W'(mag_q[ACC_W-1:NORM_W]);
      end
      S_QQ: begin
        mul_b = probe_norm_i;
      end
      S_VV: begin
        mul_a = vn_q;
      end
      default: begin
        mul_a = probe_norm_i;
        mul_b = vn_q;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_w = WIDE_W'(prod);
  assign rsum   = e_q + RND_HALF;

  // Saturate the rounded value to the output range
  assign sat_ok   = (&e_q[WIDE_W-1:DIST_W-1]) || !(|e_q[WIDE_W-1:DIST_W-1]);
  assign sat_dist = sat_ok ? e_q[DIST_W-1:0] : (e_q[WIDE_W-1] ? DIST_MIN : DIST_MAX);

  // Cosine distance: one minus dot, rounded into Q.24
  assign cos_w = COS_BIAS - {{2{dot_q[ACC_W-1]}}, dot_q};

  // Form the result word for the selected metric
  always_comb begin
    result.is_infinite = 1'b0;
    case (metric_mode_i)
      METRIC_EUCLID: result.distance = ez_q ? '0 : sat_dist;
      METRIC_COSINE: result.distance = DIST_W'(cos_w >>> 6);
      METRIC_DOT:    result.distance = sat_dist;
      default: begin
        result.distance    = DIST_MAX;
        result.is_infinite = 1'b1;
      end
    endcase
  end

  // Sequence one distance at a time, through the shared multiplier for euclidean and negated dot
  always_comb begin
    state_d     = state_q;
    dot_d       = dot_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    vn_d        = vn_q;
    pn_d        = pn_q;
    t_d         = t_q;
    e_d         = e_q;
    ez_d        = ez_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (deq) begin
          dot_d = job_i.dot;
          neg_d = job_i.dot[ACC_W-1];
          mag_d = job_i.dot[ACC_W-1] ? ACC_W'(-job_i.dot) : ACC_W'(job_i.dot);
          vn_d  = job_i.stored_norm;
          if (metric_mode_i == METRIC_EUCLID || metric_mode_i == METRIC_DOT) begin
            state_d = S_PN;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_PN: begin
        pn_d    = prod;
        state_d = S_T0;
      end
      S_T0: begin
        t_d     = prod_w;
        state_d = S_T1;
      end
      S_T1: begin
        t_d     = t_q + (prod_w << NORM_W);
        state_d = S_T2;
      end
      S_T2: begin
        t_d     = t_q + (prod_w << NORM_W);
        state_d = S_T3;
      end
      S_T3: begin
        t_d     = t_q + (prod_w << (2*NORM_W));
        state_d = S_QQ;
      end
      S_QQ: begin
        e_d     = prod_w;
        state_d = S_VV;
      end
      S_VV: begin
        e_d     = e_q + prod_w;
        state_d = S_SGN;
      end
      S_SGN: begin
        // Negative dot adds, positive dot subtracts
        t_d     = neg_q ? t_q : (~t_q + 1'b1);
        state_d = S_COMB;
      end
      S_COMB: begin
        if (metric_mode_i == METRIC_EUCLID) begin
          e_d = (e_q << DOT_FRAC) + (t_q << 1);
        end else begin
          e_d = t_q;
        end
        state_d = S_RND;
      end
      S_RND: begin
        ez_d    = e_q[WIDE_W-1] || (e_q == '0);
        e_d     = {{OUT_SH{rsum[WIDE_W-1]}}, rsum[WIDE_W-1:OUT_SH]};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          out_d       = result;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    vn_q  <= vn_d;
    pn_q  <= pn_d;
    t_q   <= t_d;
    e_q   <= e_d;
    ez_q  <= ez_d;
    out_q <= out_d;
  end

  `VDM_NEVER(a_no_overwrite, load && out_valid_q && !pop_i, "result overwritten before pop")
  `VDM_ASSERT(a_load_sets_valid, load |=> out_valid_q, "loaded result not shown")
  `VDM_ASSERT(a_deq_then_work, deq |=> state_q != S_IDLE, "dequeued job dropped")

endmodule

// ===== src/vector_distance_metric_unit.sv =====
// Vector distance unit.
// Element pairs enter through a queue-style port: present a word on
// in_data_i and raise push; the word is taken on a clock edge where full is
// low. One pair is taken per cycle while full is low; the multiply-accumulate
// sits in the front end and runs at the element rate. The pair flagged
// last_element closes the vector and its finished dot product goes into a
// four-entry job queue. The back end takes jobs one at a time and forms the
// distance on one shared 32x32 multiplier: euclidean and negated dot step
// through the norm product, four partial products, two squares, sign, combine
// and round, while cosine and the invalid mode skip the multiplier. Results
// appear in an output register: while empty is low the oldest distance sits
// on out_data_o and pop takes it. A result is loaded once the output register
// is free and can be popped on the following edge.
// A stalled receiver holds the result; the back end finishes the next job
// and waits, the job queue fills, then full rises and input stops.
// Reset clears the accumulator, the queues, metric_mode and probe_norm.
// Write metric_mode (index 0) and probe_norm (index 1) only while idle.
module vector_distance_metric_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  vdm_pkg::in_word_t                     in_data_i,
  output logic                                  empty,
  input  logic                                  pop,
  output vdm_pkg::out_word_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [vdm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [vdm_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import vdm_pkg::*;

  metric_e           mode_q;
  logic [NORM_W-1:0] qnorm_q;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= METRIC_EUCLID;
      qnorm_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METRIC_MODE: mode_q  <= metric_e'(cfg_data_i[1:0]);
        CFG_PROBE_NORM:  qnorm_q <= cfg_data_i[NORM_W-1:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  vdm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_data_i  (in_data_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  vdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .entry_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .entry_o (job_out),
    .empty_o (job_empty)
  );

  vdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .metric_mode_i (mode_q),
    .probe_norm_i  (qnorm_q),
    .job_empty_i   (job_empty),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== test/vdm_distance_checker.sv =====
module vdm_distance_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  vdm_pkg::in_word_t              in_data_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  vdm_pkg::out_word_t             out_data_i,
  input  logic                           cfg_we_i,
  input  logic [vdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             checked_o,
  output int                             fail_count_o
);
  import vdm_pkg::*;

  // Wide enough for every exact intermediate product
  localparam int WIDE_W    = 130;
  localparam int Q24_SHIFT = 38;

  localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (Q24_SHIFT - 1);
  localparam logic signed [DIST_W-1:0] DIST_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0]       DOT_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]       DOT_MIN    = -DOT_MAX - 64'sd1;

  metric_e                 metric_sel;
  logic [NORM_W-1:0]       probe_norm_q;
  logic signed [ACC_W-1:0] dot_sum;
  out_word_t               distances_due[$];
  int                      errors;
  int                      checked;

  // Add one Q1.15 product into the Q18.30 dot product, saturating at 48 bits
  function automatic logic signed [ACC_W-1:0] accumulate_dot(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [ELEM_W-1:0] vec_el,
    input logic signed [ELEM_W-1:0] qry_el
  );
    logic signed [63:0] sum;
    sum = 64'(acc) + 64'(vec_el) * 64'(qry_el);
    if (sum > DOT_MAX) sum = DOT_MAX;
    if (sum < DOT_MIN) sum = DOT_MIN;
    return sum[ACC_W-1:0];
  endfunction

  // Round a Q.62 value to Q.24 (halves up) and saturate to 64 bits
  function automatic logic signed [DIST_W-1:0] round_to_q24(
    input logic signed [WIDE_W-1:0] x
  );
    logic signed [WIDE_W-1:0] r;
    r = (x + ROUND_HALF) >>> Q24_SHIFT;
    if (r[WIDE_W-1:DIST_W-1] == '0 || r[WIDE_W-1:DIST_W-1] == '1) return r[DIST_W-1:0];
    return r[WIDE_W-1] ? DIST_MIN : DIST_MAX;
  endfunction

  function automatic out_word_t predict_distance(
    input metric_e                 metric,
    input logic [NORM_W-1:0]       qnorm,
    input logic signed [ACC_W-1:0] dot,
    input logic [NORM_W-1:0]       vnorm
  );
    out_word_t                res;
    logic signed [WIDE_W-1:0] qn_w, vn_w, mag_w, neg_scaled, sq_sum;
    logic signed [63:0]       cos_w;
    qn_w  = WIDE_W'(qnorm);
    vn_w  = WIDE_W'(vnorm);
    mag_w = WIDE_W'(dot);
    if (mag_w < 0) mag_w = -mag_w;
    // -(qn * vn * dot) in Q.62
    neg_scaled = qn_w * vn_w * mag_w;
    if (dot >= 0) neg_scaled = -neg_scaled;
    res.is_infinite = (metric == METRIC_INVALID);
    case (metric)
      METRIC_EUCLID: begin
        sq_sum = ((qn_w * qn_w + vn_w * vn_w) <<< 30) + (neg_scaled <<< 1);
        res.distance = (sq_sum > 0) ? round_to_q24(sq_sum) : '0;
      end
      METRIC_COSINE: begin
        cos_w = (64'sd1 <<< 30) - 64'(dot) + 64'sd32;
        res.distance = cos_w >>> 6;
      end
      METRIC_DOT: res.distance = round_to_q24(neg_scaled);
      default:    res.distance = DIST_MAX;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t               due;
    logic signed [ACC_W-1:0] dot_next;
    if (!rst_ni) begin
      distances_due.delete();
      metric_sel   = METRIC_EUCLID;
      probe_norm_q = '0;
      dot_sum      = '0;
      errors       = 0;
      checked      = 0;
    end else begin
      // Mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_METRIC_MODE: metric_sel = metric_e'(cfg_data_i[1:0]);
          CFG_PROBE_NORM:  probe_norm_q = cfg_data_i;
          default: ;
        endcase
      end

      // Compare the word leaving the block with the oldest prediction
      if (pop_i && !empty_i) begin
        if (distances_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual distance %h is_infinite %b",
                   $time, out_data_i.distance, out_data_i.is_infinite);
        end else begin
          due = distances_due.pop_front();
          checked++;
          if (out_data_i.distance !== due.distance) begin
            errors++;
            $display("%0t: distance expected %h actual %h", $time,
                     due.distance, out_data_i.distance);
          end
          if (out_data_i.is_infinite !== due.is_infinite) begin
            errors++;
            $display("%0t: is_infinite expected %b actual %b", $time,
                     due.is_infinite, out_data_i.is_infinite);
          end
        end
      end

      // Fold the accepted pair in; a last pair closes the vector
      if (push_i && !full_i) begin
        dot_next = accumulate_dot(dot_sum, in_data_i.vec_element, in_data_i.query_element);
        if (in_data_i.last_element) begin
          distances_due.push_back(predict_distance(metric_sel, probe_norm_q, dot_next,
                                                   in_data_i.stored_norm));
          dot_sum = '0;
        end else begin
          dot_sum = dot_next;
        end
      end
    end
    pending_o    <= distances_due.size();
    checked_o    <= checked;
    fail_count_o <= errors;
  end

endmodule

// ===== test/tb_vector_distance_metric_unit.sv =====
module tb_vector_distance_metric_unit;
  import vdm_pkg::*;

  localparam int RESET_CYCLES      = 4;
  localparam int SETTLE_CYCLES     = 20;
  localparam int QUIET_LIMIT       = 2000;
  localparam int PAIRS_PER_SEGMENT = 55;
  localparam int SATURATION_RUN    = 140;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  push     = 1'b0;
  logic                  pop      = 1'b0;
  logic                  full;
  logic                  empty;
  in_word_t              in_data  = '0;
  out_word_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int pending;
  int checked;
  int fail_count;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int pairs_sent    = 0;
  int vectors_sent  = 0;
  int quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  vector_distance_metric_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  vdm_distance_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .checked_o    (checked),
    .fail_count_o (fail_count)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  // End the run if no word moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** vector_distance_metric_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Zero, full scale, 1.0, near 1.0 or a random value
  function automatic logic [NORM_W-1:0] pick_norm();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0001_0000;
      3, 4:    return 32'h0000_8000 + $urandom_range(0, 32'h0001_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pair(input logic [ELEM_W-1:0] vec_el, input logic [ELEM_W-1:0] qry_el,
                           input logic [NORM_W-1:0] vnorm, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= '{vec_element: vec_el, query_element: qry_el, stored_norm: vnorm,
                 last_element: last};
    do @(posedge clk_i); while (full);
    pairs_sent++;
    if (last) vectors_sent++;
  endtask

  // Repeat one pair to build up a large dot product
  task automatic send_run(input logic [ELEM_W-1:0] vec_el, input logic [ELEM_W-1:0] qry_el,
                          input int count, input logic [NORM_W-1:0] vnorm);
    for (int i = 0; i < count; i++) send_pair(vec_el, qry_el, vnorm, i == count - 1);
  endtask

  // Mostly short vectors, now and then a long one
  task automatic send_random_vector();
    int len;
    len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++)
      send_pair(pick_element(), pick_element(), pick_norm(), i == len - 1);
  endtask

  // Hold input until every predicted word has come out, then let the back end settle
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input metric_e metric, input logic [NORM_W-1:0] qnorm);
    wait_idle();
    write_reg(CFG_METRIC_MODE, CFG_DATA_W'(metric));
    write_reg(CFG_PROBE_NORM, qnorm);
  endtask

  initial begin
    int                seg;
    int                seg_start;
    metric_e           metric;
    logic [NORM_W-1:0] qnorm;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Euclidean at full-scale norms: large distance, clamp at zero, zero dot
    configure(METRIC_EUCLID, 32'hFFFF_FFFF);
    send_pair(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(16'h8000, 16'h8000, 32'h0000_0000, 1'b0);
    send_pair(16'h8000, 16'h8000, 32'hFFFF_FFFF, 1'b1);
    send_pair(16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    configure(METRIC_EUCLID, 32'h0000_0000);
    send_pair(16'h8000, 16'h7FFF, 32'h0000_0000, 1'b1);

    // Cosine across dot products of 2^-15, about -1 and 0
    configure(METRIC_COSINE, 32'h0001_0000);
    send_pair(16'h8000, 16'h7FFF, $urandom, 1'b0);
    send_pair(16'h8000, 16'h8000, 32'h0001_0000, 1'b1);
    send_pair(16'h7FFF, 16'h8000, 32'h0000_0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1);

    // Negated dot at full scale, both signs
    configure(METRIC_DOT, 32'hFFFF_FFFF);
    send_pair(16'h8000, 16'h8000, 32'hFFFF_FFFF, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 32'h0001_0000, 1'b1);

    // Invalid metric flags infinity
    configure(METRIC_INVALID, 32'h1234_5678);
    send_pair(16'h0001, 16'h0002, 32'h0000_0000, 1'b0);
    send_pair(16'h0003, 16'h0004, 32'hFFFF_FFFF, 1'b1);

    configure(METRIC_EUCLID, 32'h0001_0000);
    send_random_vector();

    // Random segments: four idle profiles, three settings each
    for (int prof = 0; prof < 4; prof++) begin
      for (int k = 0; k < 3; k++) begin
        seg    = prof * 3 + k;
        metric = metric_e'(seg % 4);
        qnorm  = (seg == 0 || seg == 2) ? 32'hFFFF_FFFF : pick_norm();
        configure(metric, qnorm);
        case (prof)
          0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
          1:       begin send_idle_pct = 57; pop_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  pop_stall_pct = 57; end
          default: begin send_idle_pct = 13; pop_stall_pct = 13; end
        endcase
        seg_start = pairs_sent;
        // Long extreme vectors drive the distance into saturation
        if (seg == 0 || seg == 2)
          send_run(16'h8000, 16'h7FFF, SATURATION_RUN, 32'hFFFF_FFFF);
        if (seg == 2)
          send_run(16'h8000, 16'h8000, SATURATION_RUN, 32'hFFFF_FFFF);
        while (pairs_sent - seg_start < PAIRS_PER_SEGMENT) send_random_vector();
      end
    end

    wait_idle();
    $display("Sent %0d element pairs in %0d vectors; checked %0d distances in all four modes.",
             pairs_sent, vectors_sent, checked);
    $display("Covered zero and full-scale norms, saturation, and sender/receiver idling.");
    if (fail_count == 0) begin
      $display("** vector_distance_metric_unit: PASSED **");
    end else begin
      $display("** vector_distance_metric_unit: FAILED **");
    end
    $finish;
  end

endmodule
